// File: hdl/pko_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pko_pkg
// Shared types and constants of the 3x3 outline filter.
// ----------------------------------------------------------------------------
package pko_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;

    localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTLINE    = 2'd1;

    localparam logic [PIX_W-1:0] FOREGROUND_RESET = 8'd192;
    localparam logic [PIX_W-1:0] OUTLINE_RESET    = 8'd255;

    // result queue: power of two deep, room for two writes per cycle
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef struct packed {
        logic [PIX_W-1:0] above_pixel;
        logic [PIX_W-1:0] centre_pixel;
        logic [PIX_W-1:0] below_pixel;
        logic             row_end;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] result_pixel;
        logic             row_done;
    } out_t;

    typedef struct packed {
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] centre;
        logic [PIX_W-1:0] below;
    } column_t;

    // up to two results from one accepted column, first slot filled first
    typedef struct packed {
        logic first_valid;
        out_t first;
        logic second_valid;
        out_t second;
    } push_t;

endpackage
`default_nettype wire

// File: hdl/pko_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pko_front
// Column window, configuration registers and the outline decision.
// ----------------------------------------------------------------------------
module pko_front (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire [pko_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire [pko_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  pko_pkg::in_t                     s_data,
    input  wire                              space_ok,
    output pko_pkg::push_t                   push
);

    typedef enum logic [1:0] {
        POS_ROW_START = 2'd0,
        POS_ONE_SEEN  = 2'd1,
        POS_MANY_SEEN = 2'd2
    } position_t;

    logic [pko_pkg::PIX_W-1:0] foreground_reg;
    logic [pko_pkg::PIX_W-1:0] outline_reg;
    pko_pkg::column_t          previous_reg, previous_next;
    pko_pkg::column_t          older_reg, older_next;
    position_t                 position_reg, position_next;

    pko_pkg::column_t          col;
    logic                      accept;
    logic                      near_fg;
    logic [pko_pkg::PIX_W-1:0] decided;
    pko_pkg::push_t            push_c;

    assign s_ready = space_ok;
    assign accept  = s_valid && space_ok;

    assign col.above  = s_data.above_pixel;
    assign col.centre = s_data.centre_pixel;
    assign col.below  = s_data.below_pixel;

    always_comb begin
        near_fg = (older_reg.above == foreground_reg) || (older_reg.centre == foreground_reg)
               || (older_reg.below == foreground_reg) || (col.above == foreground_reg)
               || (col.centre == foreground_reg) || (col.below == foreground_reg)
               || (previous_reg.above == foreground_reg)
               || (previous_reg.below == foreground_reg);
        if (previous_reg.centre == pko_pkg::PIX_WHITE && near_fg) begin
            decided = outline_reg;
        end else begin
            decided = previous_reg.centre;
        end
    end

    always_comb begin
        push_c        = '0;
        previous_next = previous_reg;
        older_next    = older_reg;
        position_next = position_reg;
        case (position_reg)
            POS_ROW_START: begin
                push_c.first_valid = 1'b1;
                push_c.first       = '{result_pixel: col.centre, row_done: s_data.row_end};
                previous_next      = s_data.row_end ? pko_pkg::column_t'('0) : col;
                older_next         = '0;
                position_next      = s_data.row_end ? POS_ROW_START : POS_ONE_SEEN;
            end
            POS_ONE_SEEN: begin
                if (s_data.row_end) begin
                    push_c.first_valid = 1'b1;
                    push_c.first       = '{result_pixel: col.centre, row_done: 1'b1};
                end
            end
            default: begin
                push_c.first_valid = 1'b1;
                push_c.first       = '{result_pixel: decided, row_done: 1'b0};
                if (s_data.row_end) begin
                    push_c.second_valid = 1'b1;
                    push_c.second       = '{result_pixel: col.centre, row_done: 1'b1};
                end
            end
        endcase
        if (position_reg != POS_ROW_START) begin
            if (s_data.row_end) begin
                previous_next = '0;
                older_next    = '0;
                position_next = POS_ROW_START;
            end else begin
                older_next    = previous_reg;
                previous_next = col;
                position_next = POS_MANY_SEEN;
            end
        end
        if (!accept) begin
            push_c.first_valid  = 1'b0;
            push_c.second_valid = 1'b0;
        end
    end

    assign push = push_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            foreground_reg <= pko_pkg::FOREGROUND_RESET;
            outline_reg    <= pko_pkg::OUTLINE_RESET;
            previous_reg   <= '0;
            older_reg      <= '0;
            position_reg   <= POS_ROW_START;
        end else begin
            if (cfg_wr_en && cfg_index == pko_pkg::REG_FOREGROUND) begin
                foreground_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_index == pko_pkg::REG_OUTLINE) begin
                outline_reg <= cfg_wr_data;
            end
            if (accept) begin
                previous_reg <= previous_next;
                older_reg    <= older_next;
                position_reg <= position_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/pko_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pko_queue
// Small result queue: two writes and one read per cycle.
// ----------------------------------------------------------------------------
module pko_queue (
    input  wire             aclk,
    input  wire             aresetn,
    input  pko_pkg::push_t  push,
    output logic            space_ok,
    output logic            rd_valid,
    output pko_pkg::out_t   rd_data,
    input  wire             pop
);

    pko_pkg::out_t                   entry_reg [pko_pkg::QUEUE_DEPTH];
    logic [pko_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pko_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [pko_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [pko_pkg::QUEUE_PTR_W-1:0] wr_ptr_plus;

    assign space_ok    = count_reg <= pko_pkg::QUEUE_CNT_W'(pko_pkg::QUEUE_DEPTH - 2);
    assign rd_valid    = count_reg != '0;
    assign rd_data     = entry_reg[rd_ptr_reg];
    assign wr_ptr_plus = wr_ptr_reg + pko_pkg::QUEUE_PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + pko_pkg::QUEUE_PTR_W'(push.first_valid)
                    + pko_pkg::QUEUE_PTR_W'(push.second_valid);
        count_next  = count_reg + pko_pkg::QUEUE_CNT_W'(push.first_valid)
                    + pko_pkg::QUEUE_CNT_W'(push.second_valid)
                    - pko_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.first_valid) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid) begin
            entry_reg[wr_ptr_plus] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + pko_pkg::QUEUE_PTR_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue read while empty");

    a_second_after_first: assert property (@(posedge aclk) disable iff (!aresetn)
        push.second_valid |-> push.first_valid)
        else $error("second result pushed without first");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pko_pkg::QUEUE_CNT_W'(pko_pkg::QUEUE_DEPTH))
        else $error("queue overflow");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.first_valid |-> space_ok)
        else $error("push without room for two");
`endif

endmodule
`default_nettype wire

// File: hdl/pko_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pko_back
// Output register: drains the queue one transaction per cycle unless stalled.
// ----------------------------------------------------------------------------
module pko_back (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             rd_valid,
    input  pko_pkg::out_t   rd_data,
    output logic            pop,
    output logic            m_valid,
    input  wire             m_ready,
    output pko_pkg::out_t   m_data
);

    logic          m_valid_reg;
    pko_pkg::out_t m_data_reg;

    assign pop     = rd_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// File: hdl/pixel_outline_3x3.sv
// path: with the output free, a result enters the result queue on the edge that
//   accepts the column it becomes due on and is then registered in pko_back onto m_
//   (first column of a row at once, later columns one column behind)
// throughput: one column per cycle while s_ready is high; a row_end column can add a
//   second result, and s_ready follows the fill level of the 4-entry result queue
// reset: synchronous active-low aresetn clears the window, row position, queue and
//   output valid; foreground_colour resets to 192 and outline_colour to 255
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_outline_3x3
// 3x3 outline filter: white pixels next to foreground take the outline colour.
// ----------------------------------------------------------------------------
module pixel_outline_3x3 (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire [pko_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire [pko_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  pko_pkg::in_t                     s_data,
    output logic                             m_valid,
    input  wire                              m_ready,
    output pko_pkg::out_t                    m_data
);

    pko_pkg::push_t push;
    pko_pkg::out_t  rd_data;
    logic           space_ok;
    logic           rd_valid;
    logic           pop;

    pko_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .space_ok    (space_ok),
        .push        (push)
    );

    pko_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .pop      (pop)
    );

    pko_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

// File: tb/outline_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outline_checker
// Watches both streams and the register port of the outline filter, predicts
// every output pixel from the accepted columns and checks each one in order.
// ----------------------------------------------------------------------------
module outline_checker (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_wr_en,
    input  wire [pko_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire [pko_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire                             s_valid,
    input  wire                             s_ready,
    input  pko_pkg::in_t                    s_data,
    input  wire                             m_valid,
    input  wire                             m_ready,
    input  pko_pkg::out_t                   m_data,
    input  wire                             run_end,
    output int                              pending_results,
    output int                              fail_count
);

    localparam logic [1:0] POS_ROW_START = 2'd0;
    localparam logic [1:0] POS_ONE_SEEN  = 2'd1;
    localparam logic [1:0] POS_MANY_SEEN = 2'd2;

    logic [pko_pkg::PIX_W-1:0] fg_colour      = pko_pkg::FOREGROUND_RESET;
    logic [pko_pkg::PIX_W-1:0] outline_colour = pko_pkg::OUTLINE_RESET;
    pko_pkg::column_t          prev_col       = '0;
    pko_pkg::column_t          older_col      = '0;
    logic [1:0]                col_pos        = POS_ROW_START;
    pko_pkg::out_t             due_pixels[$];
    int                        mismatches     = 0;
    logic                      end_checked    = 1'b0;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic logic holds_foreground(input pko_pkg::column_t c);
        return c.above == fg_colour || c.centre == fg_colour || c.below == fg_colour;
    endfunction

    function automatic logic [pko_pkg::PIX_W-1:0] outline_decision(
        input pko_pkg::column_t left,
        input pko_pkg::column_t mid,
        input pko_pkg::column_t right);
        if (mid.centre != pko_pkg::PIX_WHITE)
            return mid.centre;
        if (holds_foreground(left) || holds_foreground(right) ||
            mid.above == fg_colour || mid.below == fg_colour)
            return outline_colour;
        return mid.centre;
    endfunction

    task automatic advance_window(input pko_pkg::in_t item);
        pko_pkg::column_t col;
        pko_pkg::out_t    pix;
        col.above  = item.above_pixel;
        col.centre = item.centre_pixel;
        col.below  = item.below_pixel;
        if (col_pos == POS_ROW_START) begin
            // first column of a row leaves at once, unchanged
            pix.result_pixel = col.centre;
            pix.row_done     = item.row_end;
            due_pixels.push_back(pix);
            prev_col  = item.row_end ? pko_pkg::column_t'('0) : col;
            older_col = '0;
            col_pos   = item.row_end ? POS_ROW_START : POS_ONE_SEEN;
        end else begin
            if (col_pos != POS_ONE_SEEN) begin
                pix.result_pixel = outline_decision(older_col, prev_col, col);
                pix.row_done     = 1'b0;
                due_pixels.push_back(pix);
            end
            if (item.row_end) begin
                pix.result_pixel = col.centre;
                pix.row_done     = 1'b1;
                due_pixels.push_back(pix);
                prev_col  = '0;
                older_col = '0;
                col_pos   = POS_ROW_START;
            end else begin
                older_col = prev_col;
                prev_col  = col;
                col_pos   = POS_MANY_SEEN;
            end
        end
    endtask

    task automatic check_result(input pko_pkg::out_t got);
        pko_pkg::out_t want;
        if (due_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel %h row_done %b with nothing due",
                                      got.result_pixel, got.row_done));
        end else begin
            want = due_pixels.pop_front();
            if (got.result_pixel !== want.result_pixel)
                report_mismatch($sformatf("result_pixel %h, want %h",
                                          got.result_pixel, want.result_pixel));
            if (got.row_done !== want.row_done)
                report_mismatch($sformatf("row_done %b, want %b",
                                          got.row_done, want.row_done));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fg_colour      = pko_pkg::FOREGROUND_RESET;
            outline_colour = pko_pkg::OUTLINE_RESET;
            prev_col       = '0;
            older_col      = '0;
            col_pos        = POS_ROW_START;
            due_pixels.delete();
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            if (s_valid && s_ready)
                advance_window(s_data);
            // writes never share an edge with a column transaction
            if (cfg_wr_en) begin
                if (cfg_index == pko_pkg::REG_FOREGROUND)
                    fg_colour = cfg_wr_data;
                else if (cfg_index == pko_pkg::REG_OUTLINE)
                    outline_colour = cfg_wr_data;
            end
            if (run_end && !end_checked) begin
                end_checked = 1'b1;
                if (due_pixels.size() != 0)
                    report_mismatch($sformatf("%0d pixels never arrived",
                                              due_pixels.size()));
            end
        end
        pending_results <= due_pixels.size();
        fail_count      <= mismatches;
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the 3x3 outline filter: directed rows, then random rows under
// several colour settings, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb;

    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 265;
    localparam int HALF_PHASE      = ITEMS_PER_PHASE / 2;
    localparam int PHASE_COUNT     = 6;
    localparam int LONG_HOLD       = 300;
    localparam int LIMIT_CYCLES    = 400000;

    // indexes the block must ignore
    localparam logic [pko_pkg::CFG_INDEX_W-1:0] REG_SPARE_TWO   = 2'd2;
    localparam logic [pko_pkg::CFG_INDEX_W-1:0] REG_SPARE_THREE = 2'd3;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [pko_pkg::CFG_INDEX_W-1:0] cfg_index   = pko_pkg::REG_FOREGROUND;
    logic [pko_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                            s_valid     = 1'b0;
    logic                            s_ready;
    pko_pkg::in_t                    s_data      = '0;
    logic                            m_valid;
    logic                            m_ready     = 1'b0;
    pko_pkg::out_t                   m_data;
    logic                            run_end     = 1'b0;
    int                              pending_results;
    int                              fail_count;

    logic [pko_pkg::PIX_W-1:0] fg_now      = pko_pkg::FOREGROUND_RESET;
    logic [pko_pkg::PIX_W-1:0] outline_now = pko_pkg::OUTLINE_RESET;
    int                        burst_left  = 0;
    int                        hold_ask    = 0;
    int                        hold_taken  = 0;
    int                        hold_left   = 0;
    int                        mode_left   = 0;
    int                        rx_mode     = 0;
    int                        cycle_count = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pixel_outline_3x3 dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    outline_checker window_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .run_end         (run_end),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // output side: random stall modes, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_ask != hold_taken) begin
            hold_taken = hold_ask;
            hold_left  = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
            end
            mode_left = mode_left - 1;
            case (rx_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 7) != 0);
                end
            endcase
        end
    end

    task automatic load_registers(input logic [pko_pkg::PIX_W-1:0] fg,
                                  input logic [pko_pkg::PIX_W-1:0] outline);
        // spare indexes go first and last so a decode slip shows up
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_SPARE_TWO;
        cfg_wr_data <= pko_pkg::CFG_DATA_W'($urandom_range(0, 255));
        @(posedge aclk);
        cfg_index   <= pko_pkg::REG_FOREGROUND;
        cfg_wr_data <= fg;
        @(posedge aclk);
        cfg_index   <= pko_pkg::REG_OUTLINE;
        cfg_wr_data <= outline;
        @(posedge aclk);
        cfg_index   <= REG_SPARE_THREE;
        cfg_wr_data <= pko_pkg::CFG_DATA_W'($urandom_range(0, 255));
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        fg_now      = fg;
        outline_now = outline;
    endtask

    task automatic send_column(input logic [pko_pkg::PIX_W-1:0] above,
                               input logic [pko_pkg::PIX_W-1:0] centre,
                               input logic [pko_pkg::PIX_W-1:0] below,
                               input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                              : $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data  <= '{above, centre, below, last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // lower valid, then wait for every due pixel and let the block settle
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [pko_pkg::PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0, 1, 2: return fg_now;
            3, 4, 5, 6: return pko_pkg::PIX_WHITE;
            7: return outline_now;
            default: return pko_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_row_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 1;
        if (r == 1)
            return 2;
        if (r < 17)
            return $urandom_range(3, 12);
        return $urandom_range(13, 48);
    endfunction

    task automatic random_rows(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            len = pick_row_length();
            for (int i = 0; i < len; i++) begin
                send_column(pick_pixel(), pick_pixel(), pick_pixel(), i == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        logic [pko_pkg::PIX_W-1:0] phase_fg;
        logic [pko_pkg::PIX_W-1:0] phase_outline;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_registers(8'hC0, 8'h5A);

        // single-column row, then a two-column row
        send_column(8'h00, 8'hFF, 8'h00, 1'b1);
        send_column(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_column(8'h00, 8'h00, 8'h00, 1'b1);
        // foreground in left, right, above, below and centre neighbours
        send_column(8'hC0, 8'h12, 8'h34, 1'b0);
        send_column(8'h56, 8'hFF, 8'h78, 1'b0);
        send_column(8'h9A, 8'hFF, 8'hBC, 1'b0);
        send_column(8'h00, 8'hFF, 8'hC0, 1'b0);
        send_column(8'hC0, 8'hFF, 8'h00, 1'b0);
        send_column(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_column(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_column(8'h00, 8'hC0, 8'h00, 1'b0);
        send_column(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_column(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_column(8'h00, 8'h00, 8'h00, 1'b0);
        send_column(8'hFF, 8'h7F, 8'hFF, 1'b1);
        // extremes, white interior with no foreground around
        send_column(8'h00, 8'h00, 8'h00, 1'b0);
        send_column(8'h00, 8'hFF, 8'h00, 1'b0);
        send_column(8'hFF, 8'hFF, 8'hFF, 1'b1);
        drain_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    phase_fg      = pko_pkg::FOREGROUND_RESET;
                    phase_outline = pko_pkg::OUTLINE_RESET;
                end
                1: begin
                    // outline equal to foreground
                    phase_fg      = 8'h00;
                    phase_outline = 8'h00;
                end
                2: begin
                    // foreground is white itself
                    phase_fg      = 8'hFF;
                    phase_outline = 8'h00;
                end
                3: begin
                    phase_fg      = 8'h00;
                    phase_outline = 8'hFF;
                end
                4: begin
                    phase_fg      = 8'hFF;
                    phase_outline = 8'hFF;
                end
                default: begin
                    phase_fg      = pko_pkg::PIX_W'($urandom_range(0, 255));
                    phase_outline = pko_pkg::PIX_W'($urandom_range(0, 255));
                end
            endcase
            load_registers(phase_fg, phase_outline);
            if (phase == 2) begin
                random_rows(HALF_PHASE);
                // output holds off while input keeps coming, queue backs up
                hold_ask <= hold_ask + 1;
                burst_left = 400;
                random_rows(ITEMS_PER_PHASE - HALF_PHASE);
            end else if (phase == 3) begin
                random_rows(HALF_PHASE);
                drain_results();
                random_rows(ITEMS_PER_PHASE - HALF_PHASE);
            end else begin
                random_rows(ITEMS_PER_PHASE);
            end
            drain_results();
        end

        run_end <= 1'b1;
        repeat (3) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
